/* design/bce_pkg.sv */
// ----------------------------------------------------------------------------
// bce_pkg: shared types, constants and log2 table for the BCE loss block
// Holds the field widths, controller command/status structs and the table.
// ----------------------------------------------------------------------------
package bce_pkg;

  localparam int unsigned MaxElements  = 65536;
  localparam int unsigned LogTableBits = 8;
  localparam int unsigned TabSize      = (1 << LogTableBits) + 1;
  localparam int unsigned FracShift    = 15 - LogTableBits;
  localparam int unsigned NW           = $clog2(MaxElements + 1);
  localparam int unsigned DivW         = 66;
  localparam int unsigned DivStepW     = $clog2(DivW + 1);

  localparam logic [31:0] Ln2Q32  = 32'd2977044472;
  localparam logic [36:0] AccMax  = {37{1'b1}};
  localparam logic [16:0] CntMax  = {17{1'b1}};

  typedef logic [16:0] prob_t;
  typedef logic [33:0] grad_t;
  typedef logic [19:0] mean_t;

  typedef struct packed {
    logic load;      // capture input item, start the prep sequence
    logic mean_go;   // start mean divide
    logic grad_done; // gradient quotient ready to latch
    logic finish;    // produce result word, update state
  } bce_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic last;
  } bce_sts_t;

  function automatic logic [16:0] tab_entry(input int unsigned i);
    logic [63:0] x;
    logic [16:0] y;
    begin
      if (i >= TabSize - 1) begin
        tab_entry = 17'd65536;
      end else begin
        x = (64'd1 << 30) + (64'(i) << (30 - LogTableBits));
        y = '0;
        for (int k = 15; k >= 0; k--) begin
          x = (x * x) >> 30;
          if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            y[k] = 1'b1;
          end
        end
        tab_entry = y;
      end
    end
  endfunction

  typedef logic [16:0] tab_arr_t [TabSize];

  function automatic tab_arr_t build_tab();
    tab_arr_t t;
    begin
      for (int i = 0; i < TabSize; i++) t[i] = tab_entry(i);
      build_tab = t;
    end
  endfunction

  localparam tab_arr_t LogTab = build_tab();

endpackage

/* design/bce_if.sv */
// ----------------------------------------------------------------------------
// bce_in_if / bce_out_if / bce_cfg_if: valid/ready channels of the BCE block
// Each carries valid, ready and the payload of one word.
// ----------------------------------------------------------------------------
interface bce_in_if;
  logic                 valid;
  logic                 ready;
  bce_pkg::prob_t       predicted_prob;
  bce_pkg::prob_t       target_prob;
  logic                 last_element;
  modport source (output valid, predicted_prob, target_prob, last_element, input ready);
  modport sink   (input valid, predicted_prob, target_prob, last_element, output ready);
endinterface

interface bce_out_if;
  logic                 valid;
  logic                 ready;
  bce_pkg::grad_t       gradient;
  bce_pkg::mean_t       mean_loss;
  logic                 loss_valid;
  logic                 count_mismatch;
  modport source (output valid, gradient, mean_loss, loss_valid, count_mismatch,
                  input ready);
  modport sink   (input valid, gradient, mean_loss, loss_valid, count_mismatch,
                  output ready);
endinterface

interface bce_cfg_if;
  logic        valid;
  logic        ready;
  logic [16:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* design/bce_div.sv */
// ----------------------------------------------------------------------------
// bce_div: shared restoring divider, one quotient bit per cycle
// Divides a 66-bit dividend by a 66-bit divisor.
// ----------------------------------------------------------------------------
module bce_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bce_pkg::DivW-1:0]   dividend,
  input  logic [bce_pkg::DivW-1:0]   divisor,
  output logic                       busy,
  output logic [bce_pkg::DivW-1:0]   quotient
);
  import bce_pkg::*;

  logic [DivW-1:0]     quo_r, quo_nxt;
  logic [DivW:0]       rem_r, rem_nxt;
  logic [DivW-1:0]     dsr_r, dsr_nxt;
  logic [DivStepW-1:0] cnt_r, cnt_nxt;
  logic [DivW:0]       trial;
  logic [DivW:0]       shifted;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dsr_nxt = dsr_r;
    cnt_nxt = cnt_r;
    shifted = {rem_r[DivW-1:0], quo_r[DivW-1]};
    trial   = shifted - {1'b0, dsr_r};
    if (start) begin
      quo_nxt = dividend;
      rem_nxt = '0;
      dsr_nxt = divisor;
      cnt_nxt = DivStepW'(DivW);
    end else if (cnt_r != '0) begin
      cnt_nxt = cnt_r - 1'b1;
      if (!trial[DivW]) begin
        rem_nxt = trial;
        quo_nxt = {quo_r[DivW-2:0], 1'b1};
      end else begin
        rem_nxt = shifted;
        quo_nxt = {quo_r[DivW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy     = (cnt_r != '0);
  assign quotient = quo_r;
endmodule

/* design/bce_ctrl.sv */
// ----------------------------------------------------------------------------
// bce_ctrl: controller for the BCE block
// Sequences load, gradient divide, optional mean divide and result hand-off.
// ----------------------------------------------------------------------------
module bce_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  bce_pkg::bce_sts_t sts,
  output bce_pkg::bce_cmd_t cmd
);
  import bce_pkg::*;

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StPrep  = 3'd1;
  localparam logic [2:0] StGdiv  = 3'd2;
  localparam logic [2:0] StMdiv  = 3'd3;
  localparam logic [2:0] StFin   = 3'd4;
  localparam logic [2:0] StStart = 3'd5;

  logic [2:0] state_r, state_nxt;
  logic       ovalid_r, ovalid_nxt;

  // accept a new word whenever the controller is idle
  assign in_ready  = (state_r == StIdle);
  assign out_valid = ovalid_r;

  always_comb begin
    state_nxt     = state_r;
    ovalid_nxt    = ovalid_r;
    cmd           = '0;
    if (ovalid_r && out_ready) ovalid_nxt = 1'b0;
    unique case (state_r)
      StIdle: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = StPrep;
        end
      end
      StPrep: state_nxt = StStart;
      StStart: state_nxt = StGdiv;
      StGdiv: begin
        if (!sts.div_busy) begin
          cmd.grad_done = 1'b1;
          if (sts.last) begin
            cmd.mean_go = 1'b1;
            state_nxt   = StMdiv;
          end else begin
            state_nxt = StFin;
          end
        end
      end
      StMdiv: begin
        if (!sts.div_busy) state_nxt = StFin;
      end
      StFin: begin
        if (!ovalid_r || out_ready) begin
          cmd.finish = 1'b1;
          ovalid_nxt = 1'b1;
          state_nxt  = StIdle;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= StIdle;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end
endmodule

/* design/bce_dp.sv */
// ----------------------------------------------------------------------------
// bce_dp: datapath for the BCE block
// Clamps, log lookups, loss accumulation, gradient and mean via shared divider.
// ----------------------------------------------------------------------------
module bce_dp (
  input  logic              clk,
  input  logic              rst_n,
  input  bce_pkg::bce_cmd_t cmd,
  output bce_pkg::bce_sts_t sts,
  input  bce_pkg::prob_t    in_p,
  input  bce_pkg::prob_t    in_t,
  input  logic              in_last,
  input  logic              cfg_we,
  input  logic [16:0]       cfg_data,
  output bce_pkg::grad_t    out_gradient,
  output bce_pkg::mean_t    out_mean,
  output logic              out_loss_valid,
  output logic              out_mismatch
);
  import bce_pkg::*;

  logic [16:0] count_r;
  logic [36:0] acc_r;
  logic [16:0] ecnt_r;
  logic [15:0] p_r, q_r;
  logic [16:0] t_r, n_r;
  logic        last_r, neg_r;
  logic [33:0] mag_r;       // |numerator|
  logic [32:0] pq_r;
  logic [19:0] lp_r, lq_r;  // -ln in Q.16
  logic [20:0] loss_r;
  logic [1:0]  seq_r;       // prep stages: 1 logs/pq, 2 den/loss, 3 acc/count and divide start
  logic [49:0] den_r;
  logic [33:0] grad_r;
  logic [36:0] acc_new_r;
  logic [16:0] cnt_new_r;

  // registered result
  grad_t       ogr_r;
  mean_t       omean_r;
  logic        olv_r, omm_r;

  logic              div_start;
  logic [DivW-1:0]   div_a, div_b, div_q;
  logic              div_busy;

  bce_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(div_a),
    .divisor(div_b), .busy(div_busy), .quotient(div_q)
  );

  function automatic logic [19:0] neg_ln(input logic [15:0] v);
    logic [3:0]  e;
    logic [15:0] m;
    logic [14:0] f;
    logic [LogTableBits-1:0] idx;
    logic [FracShift-1:0]    r;
    logic [16:0] a, b, frac;
    logic [24:0] prod;
    logic [20:0] l2;
    logic [52:0] w;
    begin
      e = 4'd0;
      for (int i = 0; i < 16; i++) if (v[i]) e = 4'(i);
      m    = v << (4'd15 - e);
      f    = m[14:0];
      idx  = f[14:FracShift];
      r    = f[FracShift-1:0];
      a    = LogTab[idx];
      b    = LogTab[{1'b0, idx} + 1'b1];
      prod = 25'(b - a) * 25'(r);
      frac = a + 17'(prod >> FracShift);
      l2   = {5'(5'd16 - {1'b0, e}), 16'd0} - 21'(frac);
      w    = 53'(l2) * 53'(Ln2Q32) + (53'd1 << 31);
      neg_ln = 20'(w >> 32);
    end
  endfunction

  logic [16:0] pc, tc;
  logic [16:0] nc;
  always_comb begin
    pc = in_p;
    if (pc == 17'd0) pc = 17'd1;
    if (pc > 17'd65535) pc = 17'd65535;
    tc = (in_t > 17'd65536) ? 17'd65536 : in_t;
    nc = count_r;
    if (nc == 17'd0) nc = 17'd1;
    if (nc > 17'(MaxElements)) nc = 17'(MaxElements);
  end

  logic [33:0] num_a, num_b;
  assign num_a = 34'(17'd65536 - tc) * 34'(pc[15:0]);
  assign num_b = 34'(tc) * 34'(17'd65536 - pc);

  logic [37:0] loss_sum;
  assign loss_sum = 38'(t_r) * 38'(lp_r) + 38'(17'd65536 - t_r) * 38'(lq_r) + 38'd32768;

  logic [37:0] acc_sum;
  assign acc_sum = 38'(acc_r) + 38'(loss_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 17'd1;
      acc_r   <= '0;
      ecnt_r  <= '0;
      seq_r   <= '0;
    end else begin
      if (cfg_we) count_r <= cfg_data;
      if (cmd.load) seq_r <= 2'd1;
      else if (seq_r != 2'd0) seq_r <= seq_r + 1'b1;
      if (cmd.finish) begin
        if (last_r) begin
          acc_r  <= '0;
          ecnt_r <= '0;
        end else begin
          acc_r  <= acc_new_r;
          ecnt_r <= cnt_new_r;
        end
      end
    end
    if (cmd.load) begin
      p_r    <= pc[15:0];
      q_r    <= 16'(17'd65536 - pc);
      t_r    <= tc;
      n_r    <= nc;
      last_r <= in_last;
      neg_r  <= num_a < num_b;
      mag_r  <= (num_a < num_b) ? num_b - num_a : num_a - num_b;
    end
    if (seq_r == 2'd1) begin
      lp_r <= neg_ln(p_r);
      lq_r <= neg_ln(q_r);
      pq_r <= 33'(p_r) * 33'(q_r);
    end
    if (seq_r == 2'd2) begin
      den_r  <= 50'(pq_r) * 50'(n_r);
      loss_r <= loss_sum[36:16];
    end
    if (seq_r == 2'd3) begin
      acc_new_r <= (acc_sum > 38'(AccMax)) ? AccMax : acc_sum[36:0];
      cnt_new_r <= (ecnt_r < CntMax) ? ecnt_r + 1'b1 : ecnt_r;
    end
    if (cmd.grad_done) begin
      if (neg_r) begin
        grad_r <= (div_q > 66'(34'h200000000)) ? 34'h200000000 : 34'(-div_q[33:0]);
      end else begin
        grad_r <= (div_q > 66'(34'h1FFFFFFFF)) ? 34'h1FFFFFFFF : div_q[33:0];
      end
    end
    if (cmd.finish) begin
      ogr_r   <= grad_r;
      olv_r   <= last_r;
      omean_r <= last_r ? ((div_q > 66'(20'hFFFFF)) ? 20'hFFFFF : div_q[19:0]) : '0;
      omm_r   <= last_r ? (cnt_new_r != count_r) : 1'b0;
    end
  end

  // gradient: ((mag<<17)+den)/(den<<1); mean: (acc+(n>>1))/n
  assign div_start = (seq_r == 2'd3) || cmd.mean_go;
  always_comb begin
    if (cmd.mean_go) begin
      div_a = 66'(acc_new_r) + 66'(n_r >> 1);
      div_b = 66'(n_r);
    end else begin
      div_a = (66'(mag_r) << 17) + 66'(den_r);
      div_b = 66'(den_r) << 1;
    end
  end

  // report busy in the cycle the gradient divide is launched
  assign sts.div_busy  = div_busy || (seq_r == 2'd3);
  assign sts.last      = last_r;
  assign out_gradient  = ogr_r;
  assign out_mean      = omean_r;
  assign out_loss_valid = olv_r;
  assign out_mismatch  = omm_r;
endmodule

/* design/bce_loss_and_gradient.sv */
// ----------------------------------------------------------------------------
// bce_loss_and_gradient: binary cross-entropy loss and gradient, streamed
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one word per element (prediction, target, last flag).
//   out_* : one word per input word with the gradient; on the last element
//           it also carries the mean loss, loss_valid and count_mismatch.
//   cfg_* : writes element_count (N); write only while the block is idle.
// Timing: a last element takes longer than the others; the 66-step shared
//   restoring divider runs once for the gradient and a second time for the
//   mean. One element is in work at a time.
// Reset: element_count returns to 1, accumulator and counter clear, the
//   output register empties.
// Stall: a result waits in the output register; the next word is taken
//   meanwhile and its result holds until the register frees up.
// ----------------------------------------------------------------------------
module bce_loss_and_gradient (
  input logic      clk,
  input logic      rst_n,
  bce_in_if.sink   in_ch,
  bce_out_if.source out_ch,
  bce_cfg_if.sink  cfg_ch
);
  import bce_pkg::*;

  bce_cmd_t cmd;
  bce_sts_t sts;

  assign cfg_ch.ready = 1'b1;

  bce_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .sts(sts), .cmd(cmd)
  );

  bce_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts),
    .in_p(in_ch.predicted_prob), .in_t(in_ch.target_prob),
    .in_last(in_ch.last_element),
    .cfg_we(cfg_ch.valid), .cfg_data(cfg_ch.data),
    .out_gradient(out_ch.gradient), .out_mean(out_ch.mean_loss),
    .out_loss_valid(out_ch.loss_valid), .out_mismatch(out_ch.count_mismatch)
  );
endmodule

/* tb/sv/bce_tb_if.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bce_tb_if: probe-free monitor helpers for the BCE testbench
// Holds nothing but a shared result type used by the scoreboard.
// ----------------------------------------------------------------------------
package bce_tb_pkg;
  typedef struct packed {
    bce_pkg::grad_t gradient;
    bce_pkg::mean_t mean_loss;
    logic           loss_valid;
    logic           count_mismatch;
  } bce_result_t;
endpackage

/* tb/sv/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for bce_loss_and_gradient
// Drives prediction/target words and element_count writes, predicts each
// gradient and mean loss in a scoreboard and compares every result word.
// ----------------------------------------------------------------------------
module testbench;
  import bce_pkg::*;
  import bce_tb_pkg::*;

  class bce_scoreboard;
    logic [16:0]     n_reg;
    logic [36:0]     loss_acc;
    logic [16:0]     elem_cnt;
    logic [16:0]     log2_tab [TabSize];
    bce_result_t     pending[$];
    int              errors;

    function new();
      logic [63:0] x;
      logic [16:0] y;
      for (int i = 0; i < TabSize - 1; i++) begin
        x = (64'd1 << 30) + (64'(i) << (30 - LogTableBits));
        y = '0;
        for (int k = 15; k >= 0; k--) begin
          x = (x * x) >> 30;
          if (x >= (64'd1 << 31)) begin
            x = x >> 1;
            y[k] = 1'b1;
          end
        end
        log2_tab[i] = y;
      end
      log2_tab[TabSize - 1] = 17'd65536;
      n_reg = 17'd1;
      loss_acc = '0;
      elem_cnt = '0;
      errors = 0;
    endfunction

    // -ln(v/65536) in Q.16, v in [1, 65535]
    function logic [63:0] nat_log_neg(logic [31:0] v);
      int unsigned e;
      logic [31:0] m, f, idx, r, frac;
      logic [63:0] l2;
      e = 15;
      while (e > 0 && v[e] == 1'b0) e--;
      m = v << (15 - e);
      f = (m - 32'd32768) & 32'h7FFF;
      idx = f >> FracShift;
      r = f & ((32'd1 << FracShift) - 1);
      frac = log2_tab[idx] + 32'((64'(log2_tab[idx + 1] - log2_tab[idx]) * r) >> FracShift);
      l2 = 64'(16 - e) * 64'd65536 - frac;
      return (l2 * 64'(Ln2Q32) + (64'd1 << 31)) >> 32;
    endfunction

    function void note_element(prob_t pp, prob_t tp, logic last);
      logic [63:0] p, t, q, n, lp, lq, le, den, mag, mean;
      longint num, g;
      logic neg;
      bce_result_t res;
      p = pp; t = tp;
      if (p < 1) p = 1;
      if (p > 65535) p = 65535;
      if (t > 65536) t = 65536;
      q = 65536 - p;
      n = n_reg;
      if (n < 1) n = 1;
      if (n > MaxElements) n = MaxElements;
      num = longint'((65536 - t) * p) - longint'(t * q);
      neg = num < 0;
      mag = neg ? -num : num;
      den = p * q * n;
      mag = ((mag << 17) + den) / (den << 1);
      if (neg) g = (mag > 64'd8589934592) ? -64'sd8589934592 : -longint'(mag);
      else g = (mag > 64'd8589934591) ? 64'sd8589934591 : longint'(mag);
      res.gradient = g[33:0];
      lp = nat_log_neg(p);
      lq = nat_log_neg(q);
      le = (t * lp + (65536 - t) * lq + 32768) >> 16;
      if (64'(loss_acc) + le > 64'(AccMax)) loss_acc = AccMax;
      else loss_acc = loss_acc + le;
      if (elem_cnt != CntMax) elem_cnt++;
      if (last) begin
        mean = (64'(loss_acc) + (n >> 1)) / n;
        res.mean_loss = (mean > 64'hFFFFF) ? 20'hFFFFF : mean[19:0];
        res.loss_valid = 1'b1;
        res.count_mismatch = (elem_cnt != n_reg);
        loss_acc = '0;
        elem_cnt = '0;
      end else begin
        res.mean_loss = '0;
        res.loss_valid = 1'b0;
        res.count_mismatch = 1'b0;
      end
      pending.push_back(res);
    endfunction

    function void check_result(bce_result_t got);
      bce_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result word: gradient %0h", got.gradient);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (got.gradient !== exp_r.gradient) begin
        $error("gradient: expected %0h, actual %0h", exp_r.gradient, got.gradient);
        errors++;
      end
      if (got.mean_loss !== exp_r.mean_loss) begin
        $error("mean_loss: expected %0h, actual %0h", exp_r.mean_loss, got.mean_loss);
        errors++;
      end
      if (got.loss_valid !== exp_r.loss_valid) begin
        $error("loss_valid: expected %0b, actual %0b", exp_r.loss_valid, got.loss_valid);
        errors++;
      end
      if (got.count_mismatch !== exp_r.count_mismatch) begin
        $error("count_mismatch: expected %0b, actual %0b",
               exp_r.count_mismatch, got.count_mismatch);
        errors++;
      end
    endfunction
  endclass

  localparam int IdleLimit = 20000;

  logic clk;
  logic rst_n;
  bce_in_if  in_ch ();
  bce_out_if out_ch ();
  bce_cfg_if cfg_ch ();

  bce_loss_and_gradient u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source),
    .cfg_ch (cfg_ch.sink)
  );

  bce_scoreboard sb;
  bit calm;      // no idling on either side
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.predicted_prob = '0;
    in_ch.target_prob = '0;
    in_ch.last_element = 1'b0;
    out_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data = '0;
    rst_n = 1'b0;
  end

  // sink side: random backpressure; check on each accepted word
  always @(posedge clk) begin
    bce_result_t got;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.gradient = out_ch.gradient;
      got.mean_loss = out_ch.mean_loss;
      got.loss_valid = out_ch.loss_valid;
      got.count_mismatch = out_ch.count_mismatch;
      sb.check_result(got);
    end
    out_ch.ready <= rst_n && (calm || $urandom_range(99) >= 13);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
        || (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == IdleLimit) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // valid stays high after an accept; drain() drops it, as may the next call
  task automatic send_element(prob_t p, prob_t t, logic last);
    if (!calm && $urandom_range(99) < 13) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while (!calm && $urandom_range(99) < 13);
    end
    in_ch.valid <= 1'b1;
    in_ch.predicted_prob <= p;
    in_ch.target_prob <= t;
    in_ch.last_element <= last;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_element(p, t, last);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (160) @(posedge clk);
  endtask

  task automatic write_count(logic [16:0] value);
    drain();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    sb.n_reg = value;
    cfg_ch.valid <= 1'b0;
  endtask

  function automatic prob_t rand_prob();
    case ($urandom_range(9))
      0: return prob_t'($urandom_range(3));
      1: return prob_t'($urandom_range(65536, 65533));
      2: return prob_t'($urandom_range(131071, 65537));
      default: return prob_t'($urandom_range(65536));
    endcase
  endfunction

  task automatic run_set(int len, bit honest);
    int cnt;
    cnt = honest ? len : len + $urandom_range(2) - 1;
    if (cnt < 1) cnt = 1;
    for (int i = 0; i < cnt; i++) send_element(rand_prob(), rand_prob(), i == cnt - 1);
  endtask

  initial begin
    int sent;
    logic [16:0] nval;
    sb = new();
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, beyond-range values, mismatch at reset count
    send_element(17'd0, 17'd0, 1'b1);
    send_element(17'd65536, 17'd65536, 1'b1);
    send_element(17'd131071, 17'd131071, 1'b0);
    send_element(17'd1, 17'd65536, 1'b1);
    send_element(17'd65535, 17'd0, 1'b1);
    send_element(17'd32768, 17'd32768, 1'b1);
    write_count(17'd0);
    send_element(17'd1, 17'd0, 1'b1);
    send_element(17'd65535, 17'd65536, 1'b1);
    write_count(17'd131071);
    send_element(17'd1, 17'd65536, 1'b0);
    send_element(17'd100, 17'd70000, 1'b1);
    write_count(17'd65536);
    send_element(17'd40000, 17'd1000, 1'b1);
    write_count(17'd3);
    send_element(17'd10, 17'd65535, 1'b0);
    send_element(17'd65000, 17'd3, 1'b0);
    send_element(17'd30000, 17'd60000, 1'b1);
    // hold input until all results are back
    drain();

    sent = 0;
    while (sent < 1250) begin
      if ($urandom_range(7) == 0) begin
        case ($urandom_range(3))
          0: nval = 17'd1;
          1: nval = 17'(1 << $urandom_range(16));
          2: nval = 17'($urandom_range(131071));
          default: nval = 17'($urandom_range(12, 1));
        endcase
        write_count(nval);
      end
      calm = (sent >= 500 && sent < 650);
      nval = sb.n_reg;
      if (nval >= 1 && nval <= 40 && $urandom_range(4) != 0) begin
        run_set(int'(nval), $urandom_range(4) != 0);
        sent += int'(nval);
      end else begin
        nval = 17'($urandom_range(20, 1));
        run_set(int'(nval), 1'b1);
        sent += int'(nval);
      end
    end
    calm = 1'b0;

    drain();
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
